FILE: src/tfm_pkg.sv
// ---------------------------------------------------------------------------
// tfm_pkg
// shared constants and types for the winch tension fault monitor
// ---------------------------------------------------------------------------
package tfm_pkg;

	// fault counting
	localparam int TENSION_FAULT_LIMIT = 10;
	localparam int ENCODER_FAULT_LIMIT = 5;
	localparam int FAULT_WINDOW        = 1;
	localparam int NUM_FLAGS           = 4;

	localparam int TCNT_W = 4;
	localparam int ECNT_W = 3;

	localparam logic [TCNT_W-1:0] TCNT_FULL = TCNT_W'(TENSION_FAULT_LIMIT);
	localparam logic [ECNT_W-1:0] ECNT_FULL = ECNT_W'(ENCODER_FAULT_LIMIT);
	localparam logic [31:0]       WINDOW    = 32'(FAULT_WINDOW);
	localparam logic [3:0]        FLAG_MASK = 4'((1 << NUM_FLAGS) - 1);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MIN_TENSION   = 3'd0,
		REG_MAX_TENSION   = 3'd1,
		REG_ALARM_TENSION = 3'd2,
		REG_ALARM_ACTION  = 3'd3,
		REG_STOP_FLAGS    = 3'd4,
		REG_HIGH_FLAGS    = 3'd5,
		REG_LOW_FLAGS     = 3'd6,
		REG_ERR_STOP_EN   = 3'd7
	} reg_idx_t;

	// item kinds
	localparam logic OP_TICK        = 1'b0;
	localparam logic OP_ALARM_RESET = 1'b1;

	// flag codes
	localparam logic [1:0] FLAG_NONE = 2'd0;
	localparam logic [1:0] FLAG_LOW  = 2'd1;
	localparam logic [1:0] FLAG_HIGH = 2'd2;
	localparam logic [1:0] FLAG_STOP = 2'd3;

	// alarm levels and actions
	localparam logic [1:0] ALARM_NONE = 2'd0;
	localparam logic [1:0] ALARM_WARN = 2'd1;
	localparam logic [1:0] ALARM_STOP = 2'd2;

	// stop causes
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_LOW     = 2'd1;
	localparam logic [1:0] CAUSE_HIGH    = 2'd2;
	localparam logic [1:0] CAUSE_ENCODER = 2'd3;

	typedef struct packed {
		logic               hardware_live;
		logic               motor_on;
		logic               axis_active;
		logic signed [1:0]  direction;
		logic [3:0]         flag_status;
		logic               encoder_fault;
		logic signed [15:0] tension;
		logic [31:0]        now;
	} tick_t;

	typedef struct packed {
		logic               high_tension_fault;
		logic               low_tension_fault;
		logic [1:0]         stop_cause;
		logic signed [15:0] peak_seen;
		logic [1:0]         alarm_level;
		logic               all_ok;
		logic [1:0]         flag_code;
		logic               stop_request;
	} result_t;

endpackage

FILE: src/tension_fault_monitor.sv
// ---------------------------------------------------------------------------
// tension_fault_monitor
// per-tick safety supervisor for one winch axis
// ---------------------------------------------------------------------------
// Each input beat is either a monitoring tick or an alarm reset (tuser). A
// tick checks the limit flags against the motor direction, tracks the peak
// tension, latches a tension alarm, counts out-of-range tensions and encoder
// faults in a time window that restarts after each fault, and asks for a stop
// when the hardware is not live, a flag blocks motion, the alarm acts, or a
// saturated fault count is enabled to stop the axis. Every input beat gives
// exactly one result beat. An accepted beat is held in the input register;
// the whole update is worked out from there and lands in the output
// register, and a new beat is taken every cycle while the output side keeps
// up. Configuration writes are taken at any time
// but must only be issued while no beat is in flight.
// ---------------------------------------------------------------------------
module tension_fault_monitor
	import tfm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: now[31:0], tension[47:32], encoder_fault[48], flag_status[52:49],
	//        direction[54:53], axis_active[55], motor_on[56], hardware_live[57]
	input  logic [63:0] s_tdata,
	// tuser: op (0 tick, 1 alarm reset)
	input  logic        s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: stop_request[0], flag_code[2:1], all_ok[3], alarm_level[5:4],
	//        peak_seen[21:6], stop_cause[23:22], low_tension_fault[24],
	//        high_tension_fault[25]
	output logic [31:0] m_tdata,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic signed [15:0] min_tension_q, max_tension_q, alarm_tension_q;
	logic [1:0]         alarm_action_q;
	logic [3:0]         stop_flags_q, high_flags_q, low_flags_q;
	logic               err_stop_en_q;

	// monitor state
	logic signed [15:0] peak_q, saved_bad_q;
	logic [1:0]         alarm_q, cause_q;
	logic [TCNT_W-1:0]  tcnt_q;
	logic [ECNT_W-1:0]  ecnt_q;
	logic [31:0]        tdeadline_q, edeadline_q;
	logic               was_active_q;

	// input register
	logic               v_s1;
	tick_t              tick_s1;
	logic               op_s1;

	// output register
	logic               v_s2;
	result_t            res_s2;

	logic out_free, advance;

	// next state from the beat in the input register
	logic signed [15:0] peak_n, saved_bad_n;
	logic [1:0]         alarm_n, cause_n, act;
	logic [TCNT_W-1:0]  tcnt_n;
	logic [ECNT_W-1:0]  ecnt_n;
	logic [31:0]        tdeadline_n, edeadline_n;
	logic               was_active_n, ese_n, active;
	logic               t_full, e_full;
	result_t            res_n;

	// output slot frees up when empty or being drained
	assign out_free  = !v_s2 || m_tready;
	assign advance   = v_s1 && out_free;
	assign s_tready  = !v_s1 || out_free;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = v_s2;
	assign m_tdata   = 32'(res_s2);

	always_comb begin
		peak_n       = peak_q;
		saved_bad_n  = saved_bad_q;
		alarm_n      = alarm_q;
		cause_n      = cause_q;
		tcnt_n       = tcnt_q;
		ecnt_n       = ecnt_q;
		tdeadline_n  = tdeadline_q;
		edeadline_n  = edeadline_q;
		was_active_n = was_active_q;
		ese_n        = err_stop_en_q;
		active       = tick_s1.axis_active;
		act          = alarm_action_q[1] ? ALARM_STOP : alarm_action_q;
		res_n        = '0;
		t_full       = (tcnt_q == TCNT_FULL);
		e_full       = (ecnt_q == ECNT_FULL);

		if (op_s1 == OP_ALARM_RESET) begin
			alarm_n      = ALARM_NONE;
			peak_n       = '0;
			res_n.all_ok = tick_s1.hardware_live && !((t_full || e_full) && err_stop_en_q);
		end else begin
			// edges of the axis activity
			if (active && !was_active_q)
				cause_n = CAUSE_NONE;
			if (!active && was_active_q)
				ese_n = 1'b1;

			// flag check, only with the motor on
			if (active) begin
				if (!tick_s1.motor_on) begin
					active = 1'b0;
					ese_n  = 1'b1;
				end else begin
					if ((tick_s1.flag_status & stop_flags_q & FLAG_MASK) != '0)
						res_n.flag_code = FLAG_STOP;
					else if (tick_s1.direction == 2'sd1 &&
						(tick_s1.flag_status & high_flags_q & FLAG_MASK) != '0)
						res_n.flag_code = FLAG_HIGH;
					else if (tick_s1.direction[1] &&
						(tick_s1.flag_status & low_flags_q & FLAG_MASK) != '0)
						res_n.flag_code = FLAG_LOW;
					if (res_n.flag_code != FLAG_NONE) begin
						active             = 1'b0;
						res_n.stop_request = 1'b1;
						ese_n              = 1'b1;
					end
				end
			end

			// peak tracking and alarm latch
			if (tick_s1.tension > peak_q) begin
				peak_n = tick_s1.tension;
				if (alarm_action_q != ALARM_NONE && tick_s1.tension > alarm_tension_q &&
					alarm_q == ALARM_NONE) begin
					alarm_n = act;
					if (active && act == ALARM_STOP) begin
						active             = 1'b0;
						res_n.stop_request = 1'b1;
						ese_n              = 1'b1;
					end
				end
			end

			// tension fault window
			if (tick_s1.now > tdeadline_q)
				tcnt_n = '0;
			if (tick_s1.tension > max_tension_q || tick_s1.tension < min_tension_q) begin
				if (tcnt_n < TCNT_FULL) begin
					tcnt_n = tcnt_n + 1'b1;
					if (tcnt_n == TCNT_FULL)
						saved_bad_n = tick_s1.tension;
				end
				tdeadline_n = tick_s1.now + WINDOW;
			end

			// encoder fault window
			if (tick_s1.now > edeadline_q)
				ecnt_n = '0;
			if (tick_s1.encoder_fault) begin
				if (ecnt_n < ECNT_FULL)
					ecnt_n = ecnt_n + 1'b1;
				edeadline_n = tick_s1.now + WINDOW;
			end

			t_full = (tcnt_n == TCNT_FULL);
			e_full = (ecnt_n == ECNT_FULL);

			// live check first, then saturated counts
			if (!tick_s1.hardware_live) begin
				if (active) begin
					active             = 1'b0;
					res_n.stop_request = 1'b1;
					ese_n              = 1'b1;
				end
			end else if (t_full && ese_n) begin
				if (active) begin
					active             = 1'b0;
					res_n.stop_request = 1'b1;
					ese_n              = 1'b1;
					cause_n = (saved_bad_n < min_tension_q) ? CAUSE_LOW : CAUSE_HIGH;
				end
			end else if (e_full && ese_n) begin
				if (active) begin
					active             = 1'b0;
					res_n.stop_request = 1'b1;
					ese_n              = 1'b1;
					cause_n            = CAUSE_ENCODER;
				end
			end else begin
				res_n.all_ok = 1'b1;
			end
			was_active_n = active;
		end

		res_n.alarm_level        = alarm_n;
		res_n.peak_seen          = peak_n;
		res_n.stop_cause         = cause_n;
		res_n.low_tension_fault  = t_full && (saved_bad_n < min_tension_q);
		res_n.high_tension_fault = t_full && (saved_bad_n > max_tension_q);
	end

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (out_free)
				v_s2 <= v_s1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= tick_t'(s_tdata[57:0]);
			op_s1   <= s_tuser;
		end
		if (advance)
			res_s2 <= res_n;
	end

	// monitor state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tension_q   <= 16'sd0;
			max_tension_q   <= 16'sd32767;
			alarm_tension_q <= 16'sd0;
			alarm_action_q  <= ALARM_NONE;
			stop_flags_q    <= '0;
			high_flags_q    <= '0;
			low_flags_q     <= '0;
			err_stop_en_q   <= 1'b1;
			peak_q          <= '0;
			saved_bad_q     <= '0;
			alarm_q         <= ALARM_NONE;
			cause_q         <= CAUSE_NONE;
			tcnt_q          <= '0;
			ecnt_q          <= '0;
			tdeadline_q     <= 32'd1;
			edeadline_q     <= 32'd1;
			was_active_q    <= 1'b0;
		end else begin
			if (advance) begin
				peak_q        <= peak_n;
				saved_bad_q   <= saved_bad_n;
				alarm_q       <= alarm_n;
				cause_q       <= cause_n;
				tcnt_q        <= tcnt_n;
				ecnt_q        <= ecnt_n;
				tdeadline_q   <= tdeadline_n;
				edeadline_q   <= edeadline_n;
				was_active_q  <= was_active_n;
				err_stop_en_q <= ese_n;
			end
			// writes must only come while idle; the block does not enforce it, and a write wins
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_MIN_TENSION:   min_tension_q   <= cfg_data;
					REG_MAX_TENSION:   max_tension_q   <= cfg_data;
					REG_ALARM_TENSION: alarm_tension_q <= cfg_data;
					REG_ALARM_ACTION:  alarm_action_q  <= cfg_data[1:0];
					REG_STOP_FLAGS:    stop_flags_q    <= cfg_data[3:0];
					REG_HIGH_FLAGS:    high_flags_q    <= cfg_data[3:0];
					REG_LOW_FLAGS:     low_flags_q     <= cfg_data[3:0];
					REG_ERR_STOP_EN:   err_stop_en_q   <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// fault counts saturate at their limits
	a_tcnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= TCNT_FULL)
		else $error("tension fault count past limit");

	a_ecnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= ECNT_FULL)
		else $error("encoder fault count past limit");

	// a stop always has a visible reason
	a_stop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_n.stop_request) |->
		(res_n.flag_code != FLAG_NONE || !res_n.all_ok || res_n.alarm_level == ALARM_STOP))
		else $error("stop without reason");

	// an alarm reset beat never stops the axis
	a_reset_nostop: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 == OP_ALARM_RESET) |=> (!res_s2.stop_request && res_s2.peak_seen == '0))
		else $error("alarm reset beat acted as tick");

	// a held input beat is not lost or overwritten
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !advance) |=> (v_s1 && $stable(tick_s1) && $stable(op_s1)))
		else $error("input register changed while stalled");

endmodule

FILE: tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the winch tension fault monitor
// ---------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the limit registers and of the
// monitor state, works out the result of every input beat as it is accepted
// and queues it. Each result beat is compared field by field with the oldest
// queued result. A short directed run covers the flag checks, the alarm,
// saturated fault counts and the time wrap. Random phases follow, each with
// its own register setting, run as idle and active sessions with bursts of
// tension and encoder faults. Both stream sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import tfm_pkg::*;

	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int STALL_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 20;

	// direction patterns as seen on the two-bit signed field
	localparam logic signed [1:0] DIR_ZERO = 2'b00;
	localparam logic signed [1:0] DIR_POS  = 2'b01;
	localparam logic signed [1:0] DIR_NEG2 = 2'b10;
	localparam logic signed [1:0] DIR_NEG  = 2'b11;

	// alarm action code outside the documented range, acts as stop
	localparam logic [1:0] ALARM_ACT_SPARE = 2'd3;

	// session flavor of the random stimulus
	localparam int MOOD_CALM    = 0;
	localparam int MOOD_TENSION = 1;
	localparam int MOOD_ENCODER = 2;

	typedef struct packed {
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [15:0] alarm;
		logic [1:0]         action;
		logic [3:0]         stop_f;
		logic [3:0]         high_f;
		logic [3:0]         low_f;
		logic               err_en;
	} limits_t;

	// -----------------------------------------------------------------------
	// scoreboard: private copy of the monitor, expected results in order
	// -----------------------------------------------------------------------
	class fault_scoreboard;
		// register copy
		logic signed [15:0] min_t, max_t, alarm_t;
		logic [1:0]         alarm_act;
		logic [3:0]         stop_mask, high_mask, low_mask;
		logic               err_stop_en;
		// monitor state
		logic signed [15:0] peak;
		logic [1:0]         alarm_lvl;
		logic [TCNT_W-1:0]  tension_faults;
		logic [31:0]        tension_due;
		logic signed [15:0] saved_tension;
		logic [ECNT_W-1:0]  encoder_faults;
		logic [31:0]        encoder_due;
		logic [1:0]         cause;
		logic               was_running;

		result_t pending_results[$];
		int      mismatches;

		function new();
			min_t          = 16'sd0;
			max_t          = 16'sh7FFF;
			alarm_t        = 16'sd0;
			alarm_act      = ALARM_NONE;
			stop_mask      = '0;
			high_mask      = '0;
			low_mask       = '0;
			err_stop_en    = 1'b1;
			peak           = 16'sd0;
			alarm_lvl      = ALARM_NONE;
			tension_faults = '0;
			tension_due    = 32'd1;
			saved_tension  = 16'sd0;
			encoder_faults = '0;
			encoder_due    = 32'd1;
			cause          = CAUSE_NONE;
			was_running    = 1'b0;
			mismatches     = 0;
		endfunction

		function void apply_register(reg_idx_t idx, logic [15:0] val);
			case (idx)
				REG_MIN_TENSION:   min_t = val;
				REG_MAX_TENSION:   max_t = val;
				REG_ALARM_TENSION: alarm_t = val;
				REG_ALARM_ACTION:  alarm_act = val[1:0];
				REG_STOP_FLAGS:    stop_mask = val[3:0] & FLAG_MASK;
				REG_HIGH_FLAGS:    high_mask = val[3:0] & FLAG_MASK;
				REG_LOW_FLAGS:     low_mask = val[3:0] & FLAG_MASK;
				REG_ERR_STOP_EN:   err_stop_en = val[0];
				default: ;
			endcase
		endfunction

		function result_t predict_monitor_result(logic op, tick_t t);
			result_t            r;
			logic               running, t_full, e_full;
			logic [3:0]         flags;
			logic signed [15:0] tens;
			logic signed [1:0]  dir;
			logic [1:0]         act;
			r       = '0;
			running = t.axis_active;
			flags   = t.flag_status & FLAG_MASK;
			tens    = t.tension;
			dir     = t.direction;
			if (op == OP_ALARM_RESET) begin
				alarm_lvl = ALARM_NONE;
				peak      = 16'sd0;
				t_full    = tension_faults == TCNT_FULL;
				e_full    = encoder_faults == ECNT_FULL;
				r.all_ok  = t.hardware_live && !((t_full || e_full) && err_stop_en);
			end else begin
				// session edges
				if (running && !was_running)
					cause = CAUSE_NONE;
				if (!running && was_running)
					err_stop_en = 1'b1;

				// limit flags, only while the motor really drives the axis
				if (running) begin
					if (!t.motor_on) begin
						running     = 1'b0;
						err_stop_en = 1'b1;
					end else begin
						if ((flags & stop_mask) != 0)
							r.flag_code = FLAG_STOP;
						else if (dir > 0 && (flags & high_mask) != 0)
							r.flag_code = FLAG_HIGH;
						else if (dir < 0 && (flags & low_mask) != 0)
							r.flag_code = FLAG_LOW;
						if (r.flag_code != FLAG_NONE) begin
							running        = 1'b0;
							r.stop_request = 1'b1;
							err_stop_en    = 1'b1;
						end
					end
				end

				// peak tracking and the latched alarm
				if (tens > peak) begin
					peak = tens;
					if (alarm_act != ALARM_NONE && tens > alarm_t && alarm_lvl == ALARM_NONE) begin
						act       = (alarm_act > ALARM_STOP) ? ALARM_STOP : alarm_act;
						alarm_lvl = act;
						if (running && act == ALARM_STOP) begin
							running        = 1'b0;
							r.stop_request = 1'b1;
							err_stop_en    = 1'b1;
						end
					end
				end

				// windowed fault counts, saturating
				if (t.now > tension_due)
					tension_faults = '0;
				if (tens > max_t || tens < min_t) begin
					if (tension_faults < TCNT_FULL) begin
						tension_faults = tension_faults + 1'b1;
						if (tension_faults == TCNT_FULL)
							saved_tension = tens;
					end
					tension_due = t.now + WINDOW;
				end
				if (t.now > encoder_due)
					encoder_faults = '0;
				if (t.encoder_fault) begin
					if (encoder_faults < ECNT_FULL)
						encoder_faults = encoder_faults + 1'b1;
					encoder_due = t.now + WINDOW;
				end

				t_full = tension_faults == TCNT_FULL;
				e_full = encoder_faults == ECNT_FULL;
				if (!t.hardware_live) begin
					if (running) begin
						running        = 1'b0;
						r.stop_request = 1'b1;
						err_stop_en    = 1'b1;
					end
				end else if (t_full && err_stop_en) begin
					if (running) begin
						running        = 1'b0;
						r.stop_request = 1'b1;
						err_stop_en    = 1'b1;
						cause          = (saved_tension < min_t) ? CAUSE_LOW : CAUSE_HIGH;
					end
				end else if (e_full && err_stop_en) begin
					if (running) begin
						running        = 1'b0;
						r.stop_request = 1'b1;
						err_stop_en    = 1'b1;
						cause          = CAUSE_ENCODER;
					end
				end else begin
					r.all_ok = 1'b1;
				end
				was_running = running;
			end
			r.alarm_level        = alarm_lvl;
			r.peak_seen          = peak;
			r.stop_cause         = cause;
			r.low_tension_fault  = t_full && saved_tension < min_t;
			r.high_tension_fault = t_full && saved_tension > max_t;
			return r;
		endfunction

		function void note_beat(logic op, tick_t t);
			pending_results.push_back(predict_monitor_result(op, t));
		endfunction

		function string describe(result_t r);
			return $sformatf("stop=%0d flag=%0d ok=%0d alarm=%0d peak=%0d cause=%0d lo=%0d hi=%0d",
				r.stop_request, r.flag_code, r.all_ok, r.alarm_level, r.peak_seen,
				r.stop_cause, r.low_tension_fault, r.high_tension_fault);
		endfunction

		function void check_beat(logic [31:0] data);
			result_t got, want;
			got = data[25:0];
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result beat with nothing pending: %s", $time, describe(got));
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got.stop_request !== want.stop_request || got.flag_code !== want.flag_code ||
			    got.all_ok !== want.all_ok || got.alarm_level !== want.alarm_level ||
			    got.peak_seen !== want.peak_seen || got.stop_cause !== want.stop_cause ||
			    got.low_tension_fault !== want.low_tension_fault ||
			    got.high_tension_fault !== want.high_tension_fault || data[31:26] !== '0) begin
				if (mismatches < 10) begin
					$display("%0t: result mismatch", $time);
					$display("  expected %s pad=0", describe(want));
					$display("  actual   %s pad=%0h", describe(got), data[31:26]);
				end
				mismatches++;
			end
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// dut hookup, every input known from time zero
	// -----------------------------------------------------------------------
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	tension_fault_monitor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fault_scoreboard sb = new();

	// idle percentages of the two stream sides
	int send_idle = 0;
	int recv_idle = 0;

	// random stimulus state: clock in seconds, session and its flavor
	logic [31:0] now_cur     = '0;
	int          run_left    = 0;
	logic        sess_active = 1'b0;
	int          mood        = MOOD_CALM;
	limits_t     cur_limits;

	int quiet_cycles = 0;

	always #5 clk = ~clk;

	// receiver stalls at random, changes on the falling edge
	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_idle);
	end

	// every accepted result beat goes against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata);
	end

	// watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// drivers
	// -----------------------------------------------------------------------

	// one input beat; valid stays up when the next beat follows at once
	task automatic send_item(input logic op, input tick_t beat);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {6'b0, beat};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_beat(op, beat);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.apply_register(idx, val);
	endtask

	task automatic program_limits(input limits_t c);
		cur_limits = c;
		write_reg(REG_MIN_TENSION, c.lo);
		write_reg(REG_MAX_TENSION, c.hi);
		write_reg(REG_ALARM_TENSION, c.alarm);
		write_reg(REG_ALARM_ACTION, {14'b0, c.action});
		write_reg(REG_STOP_FLAGS, {12'b0, c.stop_f});
		write_reg(REG_HIGH_FLAGS, {12'b0, c.high_f});
		write_reg(REG_LOW_FLAGS, {12'b0, c.low_f});
		write_reg(REG_ERR_STOP_EN, {15'b0, c.err_en});
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// hold the input side until every predicted result has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic tick_t make_tick(logic [31:0] now, logic signed [15:0] tension,
			logic enc, logic [3:0] flags, logic signed [1:0] dir, logic active,
			logic motor, logic live);
		tick_t t;
		t.now           = now;
		t.tension       = tension;
		t.encoder_fault = enc;
		t.flag_status   = flags;
		t.direction     = dir;
		t.axis_active   = active;
		t.motor_on      = motor;
		t.hardware_live = live;
		return t;
	endfunction

	function automatic limits_t phase_limits(int ph);
		limits_t c;
		logic signed [15:0] a, b;
		case (ph)
			0: c = '{16'sd0, 16'sd1000, 16'sd800, ALARM_WARN, 4'b0001, 4'b0010, 4'b0100, 1'b1};
			// widest band: no tension fault can occur, alarm can never trip
			1: c = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, ALARM_STOP, 4'hF, 4'hF, 4'hF, 1'b0};
			// inverted band: every tension is out of range
			2: c = '{16'sh7FFF, 16'sh8000, 16'sh8000, ALARM_ACT_SPARE, 4'b0000, 4'b1010,
				4'b0101, 1'b1};
			3: c = '{-16'sd500, 16'sd500, 16'sd300, ALARM_STOP, 4'b1000, 4'b0011, 4'b1100, 1'b1};
			4: c = '{-16'sd100, 16'sd200, 16'sd0, ALARM_NONE, 4'b0000, 4'b0000, 4'b0000, 1'b0};
			default: begin
				a = 16'($urandom_range(0, 65535));
				b = 16'($urandom_range(0, 65535));
				if (a > b && $urandom_range(0, 3) != 0) begin
					c.lo = b;
					c.hi = a;
				end else begin
					c.lo = a;
					c.hi = b;
				end
				c.alarm  = 16'($urandom_range(0, 65535));
				c.action = 2'($urandom_range(0, 3));
				c.stop_f = 4'($urandom_range(0, 15));
				c.high_f = 4'($urandom_range(0, 15));
				c.low_f  = 4'($urandom_range(0, 15));
				c.err_en = 1'($urandom_range(0, 1));
			end
		endcase
		return c;
	endfunction

	// random beat: mostly sessions of ticks with fault bursts, some noise
	task automatic make_random_item(output logic op, output tick_t beat);
		int   pick, lo_i, hi_i, val, out_pct;
		logic active;
		logic signed [1:0] dir;
		pick = $urandom_range(0, 99);
		if (pick >= 97)
			now_cur = $urandom;
		else if (pick >= 90)
			now_cur = now_cur + $urandom_range(2, 5);
		else if (pick >= 70)
			now_cur = now_cur + 1;

		if (run_left == 0) begin
			sess_active = !sess_active;
			run_left    = $urandom_range(4, 40);
			mood        = $urandom_range(MOOD_CALM, MOOD_ENCODER);
		end
		run_left--;

		if ($urandom_range(0, 99) < 5) begin
			// noise: any bit pattern at all
			op   = 1'($urandom_range(0, 1));
			beat = 58'({$urandom, $urandom});
		end else begin
			op   = ($urandom_range(0, 99) < 4) ? OP_ALARM_RESET : OP_TICK;
			lo_i = cur_limits.lo;
			hi_i = cur_limits.hi;
			out_pct = (mood == MOOD_TENSION) ? 55 : 8;
			pick = $urandom_range(0, 99);
			if (pick < out_pct) begin
				if ($urandom_range(0, 1) == 1 && lo_i > -32768) begin
					val = lo_i - int'($urandom_range(1, 40));
					if (val < -32768)
						val = -32768;
				end else if (hi_i < 32767) begin
					val = hi_i + int'($urandom_range(1, 40));
					if (val > 32767)
						val = 32767;
				end else begin
					val = int'($urandom_range(0, 65535)) - 32768;
				end
			end else if (pick < 85 && lo_i <= hi_i) begin
				val = lo_i + int'($urandom_range(0, hi_i - lo_i));
			end else begin
				val = int'($urandom_range(0, 65535)) - 32768;
			end

			pick = $urandom_range(0, 99);
			if (pick < 40)
				dir = DIR_POS;
			else if (pick < 75)
				dir = DIR_NEG;
			else if (pick < 93)
				dir = DIR_ZERO;
			else
				dir = DIR_NEG2;

			active = sess_active ^ ($urandom_range(0, 99) < 3);
			beat = make_tick(now_cur, val[15:0],
				$urandom_range(0, 99) < ((mood == MOOD_ENCODER) ? 50 : 3),
				($urandom_range(0, 99) < 80) ? 4'b0000 : 4'($urandom_range(0, 15)),
				dir, active, $urandom_range(0, 99) < 96, $urandom_range(0, 99) < 96);
		end
	endtask

	// -----------------------------------------------------------------------
	// stimulus
	// -----------------------------------------------------------------------
	initial begin
		logic  op;
		tick_t beat;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed part, no idling
		program_limits('{-16'sd1000, 16'sd1000, 16'sd500, ALARM_ACT_SPARE, 4'b0001,
			4'b0010, 4'b0100, 1'b1});
		send_item(OP_TICK, make_tick(32'd0, 16'sd0, 1'b0, 4'h0, DIR_POS, 1'b0, 1'b1, 1'b1));
		// high flag while moving up
		send_item(OP_TICK, make_tick(32'd0, 16'sd100, 1'b0, 4'b0010, DIR_POS, 1'b1, 1'b1, 1'b1));
		// low flag while moving down, leaving idle again
		send_item(OP_TICK, make_tick(32'd0, 16'sd100, 1'b0, 4'b0100, DIR_NEG, 1'b1, 1'b1, 1'b1));
		// standing still: only stop flags count
		send_item(OP_TICK, make_tick(32'd0, 16'sd50, 1'b0, 4'b0110, DIR_ZERO, 1'b1, 1'b1, 1'b1));
		send_item(OP_TICK, make_tick(32'd0, 16'sd50, 1'b0, 4'b0001, DIR_ZERO, 1'b1, 1'b1, 1'b1));
		// direction pattern 2 reads as negative
		send_item(OP_TICK, make_tick(32'd0, 16'sd50, 1'b0, 4'b0100, DIR_NEG2, 1'b1, 1'b1, 1'b1));
		// motor off while active, then idle axis: flags ignored
		send_item(OP_TICK, make_tick(32'd0, 16'sd50, 1'b0, 4'hF, DIR_POS, 1'b1, 1'b0, 1'b1));
		send_item(OP_TICK, make_tick(32'd0, 16'sd50, 1'b0, 4'hF, DIR_NEG, 1'b0, 1'b1, 1'b1));
		// top tension trips the alarm with the spare action code
		send_item(OP_TICK, make_tick(32'd1, 16'sh7FFF, 1'b0, 4'h0, DIR_POS, 1'b1, 1'b1, 1'b1));
		send_item(OP_ALARM_RESET, make_tick(32'd1, 16'sd0, 1'b0, 4'h0, DIR_ZERO, 1'b0, 1'b0, 1'b1));
		// hardware not live, bottom tension
		send_item(OP_TICK, make_tick(32'd1, 16'sh8000, 1'b0, 4'h0, DIR_POS, 1'b1, 1'b1, 1'b0));
		// encoder count runs full and stops the axis with a cause
		repeat (5)
			send_item(OP_TICK, make_tick(32'd2, 16'sd10, 1'b1, 4'h0, DIR_POS, 1'b1, 1'b1, 1'b1));
		send_item(OP_ALARM_RESET, make_tick(32'd2, 16'sd0, 1'b0, 4'h0, DIR_ZERO, 1'b1, 1'b1, 1'b1));
		// deadline wraps past the top of the clock
		send_item(OP_TICK, make_tick(32'hFFFF_FFFF, 16'sd0, 1'b1, 4'h0, DIR_POS, 1'b1, 1'b1, 1'b1));
		send_item(OP_TICK, make_tick(32'hFFFF_FFFF, 16'sd0, 1'b0, 4'h0, DIR_POS, 1'b1, 1'b1, 1'b1));
		send_item(OP_TICK, make_tick(32'h8000_0000, -16'sd1, 1'b0, 4'h0, DIR_POS, 1'b1, 1'b1, 1'b1));

		// random phases: sender light / receiver heavy idling, then swapped, then none
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle = (ph < 2) ? 11 : (ph < 4) ? 86 : 0;
			recv_idle = (ph < 2) ? 86 : (ph < 4) ? 11 : 0;
			wait_drained();
			program_limits(phase_limits(ph));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 149) == 0)
					wait_drained();
				make_random_item(op, beat);
				send_item(op, beat);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
